### design/rtpmf_pkg.sv
// Package for the resonant two-pole multimode filter.
// Shared constants, codes, sequencer state and control struct.
// No dependencies.
`default_nettype none

package rtpmf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STATE_WIDTH_DEF  = 24;

  // coefficient register width and fixed-point shifts
  localparam int COEF_W    = 16;
  localparam int FB_SHIFT  = 12;  // feedback is Q4.12
  localparam int CUT_SHIFT = 16;  // cutoff is Q0.16

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

  typedef enum logic [1:0] {
    MODE_LP    = 2'd0,
    MODE_HP    = 2'd1,
    MODE_BP    = 2'd2,
    MODE_NOTCH = 2'd3
  } rtpmf_mode_t;

  // multiplier operand source
  typedef enum logic [1:0] {
    OP_BP    = 2'd0,
    OP_DRIVE = 2'd1,
    OP_DIFF  = 2'd2
  } rtpmf_opsel_t;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MFB  = 9'b000000010,
    ST_DRV  = 9'b000000100,
    ST_MF1  = 9'b000001000,
    ST_UP1  = 9'b000010000,
    ST_DIF  = 9'b000100000,
    ST_MF2  = 9'b001000000,
    ST_UP2  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } rtpmf_state_t;

  typedef struct packed {
    logic         idle;
    logic         mul_en;
    rtpmf_opsel_t opsel;
    logic         coef_cut;
    logic         ld_drive;
    logic         upd_first;
    logic         ld_diff;
    logic         upd_second;
    logic         ld_out;
  } rtpmf_ctl_t;

endpackage

`default_nettype wire

### design/rtpmf_in_if.sv
// Input sample channel: valid/ready handshake with a signed sample.
// Width default from rtpmf_pkg.
`default_nettype none

interface rtpmf_in_if #(
  parameter int W = rtpmf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### design/rtpmf_out_if.sv
// Result sample channel: valid/ready handshake with a signed sample.
// Width default from rtpmf_pkg.
`default_nettype none

interface rtpmf_out_if #(
  parameter int W = rtpmf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### design/rtpmf_mul.sv
// Shared multiplier: unsigned coefficient times signed operand, registered.
// Uses rtpmf_pkg for the coefficient width.
`default_nettype none

module rtpmf_mul #(
  parameter int OPW = 32
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [rtpmf_pkg::COEF_W-1:0]           coef,
  input  logic signed [OPW-1:0]                  opnd,
  output logic signed [OPW+rtpmf_pkg::COEF_W:0]  prod
);
  import rtpmf_pkg::*;

  localparam int PW = OPW + COEF_W + 1;

  logic signed [PW-1:0] prod_r;
  logic signed [COEF_W:0] coef_s;

  assign coef_s = $signed({1'b0, coef});

  // both operands widened to the full product width before the multiply
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(coef_s) * PW'(opnd);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

### design/rtpmf_ctrl.sv
// Sequencer for the filter: steps one transaction through the shared multiplier.
// Uses rtpmf_pkg for state encoding and the control struct.
`default_nettype none

module rtpmf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_busy,
  output rtpmf_pkg::rtpmf_ctl_t ctl
);
  import rtpmf_pkg::*;

  rtpmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.opsel = OP_BP;
    unique case (state_r)
      ST_IDLE: begin
        ctl.idle = 1'b1;
        if (in_valid) state_nxt = ST_MFB;
      end
      ST_MFB: begin
        ctl.mul_en = 1'b1;
        ctl.opsel  = OP_BP;
        state_nxt  = ST_DRV;
      end
      ST_DRV: begin
        ctl.ld_drive = 1'b1;
        state_nxt    = ST_MF1;
      end
      ST_MF1: begin
        ctl.mul_en   = 1'b1;
        ctl.opsel    = OP_DRIVE;
        ctl.coef_cut = 1'b1;
        state_nxt    = ST_UP1;
      end
      ST_UP1: begin
        ctl.upd_first = 1'b1;
        state_nxt     = ST_DIF;
      end
      ST_DIF: begin
        ctl.ld_diff = 1'b1;
        state_nxt   = ST_MF2;
      end
      ST_MF2: begin
        ctl.mul_en   = 1'b1;
        ctl.opsel    = OP_DIFF;
        ctl.coef_cut = 1'b1;
        state_nxt    = ST_UP2;
      end
      ST_UP2: begin
        ctl.upd_second = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          ctl.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/resonant_two_pole_multimode_filter.sv
// Top level of the resonant two-pole multimode filter: datapath, registers, output stage.
// Depends on rtpmf_pkg, rtpmf_in_if, rtpmf_out_if, rtpmf_mul and rtpmf_ctrl.
//
//   port group | dir | handshake        | payload
//   -----------+-----+------------------+-------------------------------------
//   in_chan    | in  | valid / ready    | sample_in  signed SAMPLE_WIDTH
//   out_chan   | out | valid / ready    | sample_out signed SAMPLE_WIDTH
//   cfg_*      | in  | cfg_we           | cfg_index 2b, cfg_wdata 16b
//
// A transaction runs from acceptance through 8 sequencer steps to the result load;
// three of them are passes through the one shared multiplier.
// in_chan.ready is high only while the sequencer is idle.
// A result waiting in the output register does not block acceptance; only the
// final load step waits for the output register to empty.
// rst_n is synchronous: it clears both filter states, the coefficients, the mode
// and the sequencer.
`default_nettype none

module resonant_two_pole_multimode_filter #(
  parameter int SAMPLE_WIDTH = rtpmf_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = rtpmf_pkg::STATE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rtpmf_in_if.sink                         in_chan,
  rtpmf_out_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [rtpmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpmf_pkg::COEF_W-1:0]     cfg_wdata
);
  import rtpmf_pkg::*;

  // guard bits between sample and state formats (may be negative)
  localparam int G  = STATE_WIDTH - SAMPLE_WIDTH;
  localparam int GP = (G >= 0) ? G : 0;
  localparam int GN = (G < 0) ? -G : 0;
  // width for format conversion, covers both directions
  localparam int TW = ((STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH) + 3;
  // multiplier operand: drive term needs STATE_WIDTH+6 bits
  localparam int DW = STATE_WIDTH + 8;
  localparam int PW = DW + COEF_W + 1;

  localparam logic signed [PW-1:0] ST_MAX =
    {{(PW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [TW-1:0] SMP_MAX =
    {{(TW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [TW-1:0] SMP_MIN = ~SMP_MAX;

  // clamp a wide sum to the state range
  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [PW-1:0] v);
    logic signed [STATE_WIDTH-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX[STATE_WIDTH-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[STATE_WIDTH-1:0];
    end else begin
      r = v[STATE_WIDTH-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [COEF_W-1:0] cutoff_r;
  logic [COEF_W-1:0] feedback_r;
  rtpmf_mode_t       mode_r;

  // filter state and per-transaction working registers
  logic signed [STATE_WIDTH-1:0] first_r;
  logic signed [STATE_WIDTH-1:0] second_r;
  logic signed [STATE_WIDTH:0]   hp_r;
  logic signed [STATE_WIDTH:0]   bp_r;
  logic signed [DW-1:0]          drive_r;
  logic signed [STATE_WIDTH:0]   diff_r;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r;

  rtpmf_ctl_t ctl;
  logic       in_acc;

  logic signed [TW-1:0]          s_ext;
  logic signed [TW-1:0]          x_sc;
  logic signed [STATE_WIDTH-1:0] x_st;
  logic signed [STATE_WIDTH:0]   hp_nxt;
  logic signed [STATE_WIDTH:0]   bp_nxt;

  logic signed [DW-1:0]  opnd;
  logic [COEF_W-1:0]     coef;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  drive_sum;
  logic signed [PW-1:0]  first_sum;
  logic signed [PW-1:0]  second_sum;

  logic signed [STATE_WIDTH+1:0] sel;
  logic signed [TW-1:0]          sel_ext;
  logic signed [TW-1:0]          sel_sc;
  logic signed [SAMPLE_WIDTH-1:0] out_nxt;

  rtpmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .out_busy (out_valid_r && !out_chan.ready),
    .ctl      (ctl)
  );

  assign in_chan.ready = ctl.idle;
  assign in_acc        = in_chan.valid && ctl.idle;

  // configuration writes; index 3 does nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r   <= '0;
      feedback_r <= '0;
      mode_r     <= MODE_LP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CUTOFF:   cutoff_r   <= cfg_wdata;
        CFG_FEEDBACK: feedback_r <= cfg_wdata;
        CFG_MODE:     mode_r     <= rtpmf_mode_t'(cfg_wdata[1:0]);
        default:      ;
      endcase
    end
  end

  // sample to state format: scale by 2^G, or floor shift when G is negative
  assign s_ext  = TW'(in_chan.sample_in);
  assign x_sc   = (G >= 0) ? (s_ext <<< GP) : (s_ext >>> GN);
  assign x_st   = x_sc[STATE_WIDTH-1:0];
  assign hp_nxt = (STATE_WIDTH+1)'(x_st) - (STATE_WIDTH+1)'(first_r);
  assign bp_nxt = (STATE_WIDTH+1)'(first_r) - (STATE_WIDTH+1)'(second_r);

  // shared multiplier: feedback*bp, then cutoff*drive, then cutoff*diff
  always_comb begin
    unique case (ctl.opsel)
      OP_BP:    opnd = DW'(bp_r);
      OP_DRIVE: opnd = drive_r;
      OP_DIFF:  opnd = DW'(diff_r);
      default:  opnd = DW'(bp_r);
    endcase
  end

  assign coef = ctl.coef_cut ? cutoff_r : feedback_r;

  rtpmf_mul #(
    .OPW (DW)
  ) u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .coef (coef),
    .opnd (opnd),
    .prod (prod)
  );

  // arithmetic shifts give floor rounding
  assign drive_sum  = PW'(hp_r) + (prod >>> FB_SHIFT);
  assign first_sum  = PW'(first_r) + (prod >>> CUT_SHIFT);
  assign second_sum = PW'(second_r) + (prod >>> CUT_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
    end else begin
      if (ctl.upd_first)  first_r  <= sat_state(first_sum);
      if (ctl.upd_second) second_r <= sat_state(second_sum);
    end
  end

  // working registers carry no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hp_r <= hp_nxt;
      bp_r <= bp_nxt;
    end
    if (ctl.ld_drive) drive_r <= drive_sum[DW-1:0];
    if (ctl.ld_diff)  diff_r  <= (STATE_WIDTH+1)'(first_r) - (STATE_WIDTH+1)'(second_r);
  end

  // mode select; bandpass is the pre-update term
  always_comb begin
    unique case (mode_r)
      MODE_LP:    sel = (STATE_WIDTH+2)'(second_r);
      MODE_HP:    sel = (STATE_WIDTH+2)'(hp_r);
      MODE_BP:    sel = (STATE_WIDTH+2)'(bp_r);
      MODE_NOTCH: sel = (STATE_WIDTH+2)'(second_r) + (STATE_WIDTH+2)'(hp_r);
      default:    sel = (STATE_WIDTH+2)'(second_r);
    endcase
  end

  // state to sample format, then clamp
  assign sel_ext = TW'(sel);
  assign sel_sc  = (G >= 0) ? (sel_ext >>> GP) : (sel_ext <<< GN);

  always_comb begin
    if (sel_sc > SMP_MAX) begin
      out_nxt = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (sel_sc < SMP_MIN) begin
      out_nxt = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      out_nxt = sel_sc[SAMPLE_WIDTH-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) out_data_r <= out_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;

  // an accepted transaction starts with the feedback multiply
  a_start_mfb: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (ctl.mul_en && ctl.opsel == OP_BP && !ctl.coef_cut))
    else $error("sequencer did not start feedback multiply after accept");

  // filter states move only in their update steps
  a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.upd_first |=> $stable(first_r))
    else $error("first stage changed outside its update step");

  a_second_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.upd_second |=> $stable(second_r))
    else $error("second stage changed outside its update step");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out |-> (!out_valid_r || out_chan.ready))
    else $error("pending result overwritten");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.ld_out))
    else $error("result valid raised without a load step");

endmodule

`default_nettype wire

### bench/rtpmf_checker.sv
// Scoreboard for the resonant two-pole multimode filter: mirrors the register
// writes, predicts each sample_out from the accepted samples and compares.
// Depends on rtpmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpmf_checker
  import rtpmf_pkg::*;
#(
  parameter int SW  = SAMPLE_WIDTH_DEF,
  parameter int STW = STATE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  input  logic                 smp_valid,
  input  logic                 smp_ready,
  input  logic signed [SW-1:0] smp_data,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  logic signed [SW-1:0] res_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int GUARD = STW - SW;

  longint      stage1, stage2;   // states, sample value times 2^GUARD
  logic [15:0] cut, fbk;
  rtpmf_mode_t mode;
  int          err_count = 0;

  logic signed [SW-1:0] expected_samples [$];

  assign mismatches = err_count;

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // one filter step; >>> on longint is a floor shift
  function automatic logic signed [SW-1:0] filter_response(input logic signed [SW-1:0] smp);
    longint x, hp, bp, drive, pick, f, fb;
    f     = longint'(cut);
    fb    = longint'(fbk);
    x     = longint'(smp) * (longint'(1) <<< GUARD);
    hp    = x - stage1;
    bp    = stage1 - stage2;
    drive = hp + ((fb * bp) >>> FB_SHIFT);
    stage1 = clamp(stage1 + ((f * drive) >>> CUT_SHIFT), STW);
    stage2 = clamp(stage2 + ((f * (stage1 - stage2)) >>> CUT_SHIFT), STW);
    case (mode)
      MODE_LP: pick = stage2;
      MODE_HP: pick = hp;
      MODE_BP: pick = bp;   // taken before the update
      default: pick = stage2 + hp;
    endcase
    return SW'(clamp(pick >>> GUARD, SW));
  endfunction

  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    int                   delta;
    delta = 0;
    if (!rst_n) begin
      stage1 = 0;
      stage2 = 0;
      cut    = '0;
      fbk    = '0;
      mode   = MODE_LP;
      expected_samples.delete();
      outstanding <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample_out expected none got %0d", $time, res_data);
          err_count++;
        end else begin
          want = expected_samples.pop_front();
          delta--;
          if (res_data !== want) begin
            $display("%0t: sample_out expected %0d got %0d", $time, want, res_data);
            err_count++;
          end
        end
      end
      if (smp_valid && smp_ready) begin
        expected_samples.push_back(filter_response(smp_data));
        delta++;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CUTOFF:   cut  = cfg_wdata;
          CFG_FEEDBACK: fbk  = cfg_wdata;
          CFG_MODE:     mode = rtpmf_mode_t'(cfg_wdata[1:0]);
          default: ;
        endcase
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
// Top of the filter bench: clock, reset, register programming, sample stimulus
// and the verdict. Depends on rtpmf_pkg, the channel interfaces, the filter and
// rtpmf_checker.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import rtpmf_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int LIMIT_CYCLES = 500_000;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_ITEMS  = 100;
  // index 3 decodes to nothing; writes there must leave the filter alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    SIG_NOISE,
    SIG_SQUARE,
    SIG_QUIET,
    SIG_EDGES
  } sig_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 tx_valid = 1'b0;
  logic signed [SW-1:0] tx_sample = '0;
  logic                 rx_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  int mismatches, outstanding;
  int cycles = 0;
  int burst_left = 0;

  // receiver stall pattern state
  int rx_style = 0;
  int rx_left = 0;

  rtpmf_in_if  #(.W(SW)) in_ch ();
  rtpmf_out_if #(.W(SW)) out_ch ();

  assign in_ch.valid     = tx_valid;
  assign in_ch.sample_in = tx_sample;
  assign out_ch.ready    = rx_ready;

  resonant_two_pole_multimode_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rtpmf_checker #(.SW(SW)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .smp_valid   (in_ch.valid),
    .smp_ready   (in_ch.ready),
    .smp_data    (in_ch.sample_in),
    .res_valid   (out_ch.valid),
    .res_ready   (out_ch.ready),
    .res_data    (out_ch.sample_out),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: runs of always-ready, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 2);
      rx_left  <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      0:       rx_ready <= 1'b1;
      1:       rx_ready <= ($urandom_range(0, 3) != 0);
      default: rx_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Offer one sample and hold it until it is accepted. Bursts of
  // back-to-back offers are broken by short gaps so they land on every step
  // of the sequencer.
  task automatic send_sample(input logic signed [SW-1:0] s);
    if (burst_left == 0) begin
      tx_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    tx_valid  <= 1'b1;
    tx_sample <= s;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    burst_left--;
  endtask

  // Drop valid and wait for every predicted sample to come back, so the
  // registers can be rewritten with the sequencer idle.
  task automatic drain();
    tx_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all three registers, plus a junk write to the unused index. The
  // mode word carries random upper bits, which the block must mask off.
  task automatic program_filter(input logic [15:0] cut, input logic [15:0] fb,
                                input rtpmf_mode_t m);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CUTOFF;
    cfg_wdata <= cut;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_index <= CFG_FEEDBACK;
    cfg_wdata <= fb;
    @(posedge clk);
    cfg_index <= CFG_MODE;
    cfg_wdata <= {14'($urandom), m};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_extremes();
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
  endtask

  function automatic logic [15:0] pick_cutoff();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(1, 2048));   // audio-like corner
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_feedback();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(3000, 6000)); // around unity
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] make_sample(input sig_style_t st, input int n,
                                                        input int period);
    case (st)
      SIG_SQUARE: return ((n / period) % 2) ? -16'sh8000 : 16'sh7fff;
      SIG_QUIET:  return SW'($signed($urandom_range(0, 511)) - 256);
      SIG_EDGES:
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return -16'sh8000;
          2:       return -16'sh0001;
          default: return SW'($urandom);
        endcase
      default:    return SW'($urandom);
    endcase
  endfunction

  initial begin
    sig_style_t st;
    int         period;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings straight out of reset: zero cutoff, lowpass.
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh0001);
    drain();

    // Widest cutoff and feedback in notch mode: drives both states into saturation.
    program_filter(16'hffff, 16'hffff, MODE_NOTCH);
    send_extremes();
    drain();

    program_filter(16'hffff, 16'h0000, MODE_HP);
    send_extremes();
    drain();

    program_filter(16'h8000, 16'h1000, MODE_BP);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    drain();

    program_filter(16'h0001, 16'h2000, MODE_LP);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh7fff);
    drain();

    // Random phases: fresh coefficients and mode each time, varied signal shapes.
    for (int p = 0; p < RAND_PHASES; p++) begin
      program_filter(pick_cutoff(), pick_feedback(), rtpmf_mode_t'($urandom_range(0, 3)));
      st     = sig_style_t'($urandom_range(0, 3));
      period = $urandom_range(1, 20);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(make_sample(st, n, period));
      drain();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/rtpmf_pkg.sv
design/rtpmf_in_if.sv
design/rtpmf_out_if.sv
design/rtpmf_mul.sv
design/rtpmf_ctrl.sv
design/resonant_two_pole_multimode_filter.sv
bench/rtpmf_checker.sv
bench/testbench.sv
